// File: src/smpg_pkg.sv
package smpg_pkg;

    localparam logic [7:0] MinWaitReset = 8'd10;
    localparam logic [9:0] DutyMax      = 10'd1023;

    typedef struct packed {
        logic [7:0] velocity;
        logic       mod_enable;
    } t_in;

    typedef struct packed {
        logic [9:0] duty_a;
        logic [9:0] duty_b;
        logic [9:0] duty_c;
        logic [9:0] duty_d;
        logic [2:0] microstep;
        logic [1:0] phase_quadrant;
    } t_out;

    // angle state after this tick's update, as seen by the duty logic
    typedef struct packed {
        logic [2:0] angle;
        logic [1:0] quadrant;
        logic [3:0] mod_index;
        logic       mod_on;
    } t_step_info;

    function automatic logic [7:0] quarter_sine(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'd50;
            3'd1:    v = 8'd98;
            3'd2:    v = 8'd142;
            3'd3:    v = 8'd180;
            3'd4:    v = 8'd212;
            3'd5:    v = 8'd236;
            3'd6:    v = 8'd250;
            3'd7:    v = 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] mod_gain(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'd159;
            4'd1:    v = 8'd177;
            4'd2:    v = 8'd156;
            4'd3:    v = 8'd166;
            4'd4:    v = 8'd160;
            4'd5:    v = 8'd160;
            4'd6:    v = 8'd155;
            4'd7:    v = 8'd154;
            4'd8:    v = 8'd163;
            4'd9:    v = 8'd171;
            4'd10:   v = 8'd146;
            4'd11:   v = 8'd160;
            4'd12:   v = 8'd161;
            4'd13:   v = 8'd168;
            4'd14:   v = 8'd161;
            4'd15:   v = 8'd128;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/smpg_step.sv
module smpg_step (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  logic [7:0]              i_min_wait,
    input  smpg_pkg::t_in           i_item,
    output smpg_pkg::t_step_info    o_info
);

    logic [8:0] r_wait;
    logic [2:0] r_angle;
    logic [1:0] r_quad;
    logic [3:0] r_mod;

    logic [8:0] n_wait;
    logic [2:0] n_angle;
    logic [1:0] n_quad;
    logic [3:0] n_mod;
    logic [8:0] threshold;

    always_comb begin
        threshold = {1'b0, i_min_wait} + {1'b0, i_item.velocity};
        n_wait    = r_wait + 9'd1;
        n_angle   = r_angle;
        n_quad    = r_quad;
        if (n_wait > threshold) begin
            n_wait  = 9'd0;
            n_angle = r_angle + 3'd1;
            if (n_angle == 3'd0) begin
                n_quad = r_quad + 2'd1;
            end
        end
        n_mod = i_item.mod_enable ? r_mod + 4'd1 : r_mod;

        // modulation uses the index before it moves on
        o_info.angle     = n_angle;
        o_info.quadrant  = n_quad;
        o_info.mod_index = r_mod;
        o_info.mod_on    = i_item.mod_enable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait  <= '0;
            r_angle <= '0;
            r_quad  <= '0;
            r_mod   <= '0;
        end else if (i_advance) begin
            r_wait  <= n_wait;
            r_angle <= n_angle;
            r_quad  <= n_quad;
            r_mod   <= n_mod;
        end
    end

endmodule

// File: src/smpg_duty.sv
module smpg_duty (
    input  smpg_pkg::t_step_info    i_info,
    output smpg_pkg::t_out          o_result
);

    logic [7:0]  sin_base;
    logic [7:0]  cos_base;
    logic [7:0]  gain;
    logic [15:0] sin_prod;
    logic [15:0] cos_prod;
    logic [11:0] sin_amp;
    logic [11:0] cos_amp;
    logic [9:0]  sin_duty;
    logic [9:0]  cos_duty;

    always_comb begin
        sin_base = smpg_pkg::quarter_sine(i_info.angle);
        cos_base = smpg_pkg::quarter_sine(3'd7 - i_info.angle);
        gain     = smpg_pkg::mod_gain(i_info.mod_index);
        sin_prod = sin_base * gain;
        cos_prod = cos_base * gain;

        if (i_info.mod_on) begin
            sin_amp = sin_prod[15:4];
            cos_amp = cos_prod[15:4];
        end else begin
            sin_amp = {4'd0, sin_base};
            cos_amp = {4'd0, cos_base};
        end

        sin_duty = (sin_amp > {2'd0, smpg_pkg::DutyMax}) ? smpg_pkg::DutyMax : sin_amp[9:0];
        cos_duty = (cos_amp > {2'd0, smpg_pkg::DutyMax}) ? smpg_pkg::DutyMax : cos_amp[9:0];

        o_result                = '0;
        o_result.microstep      = i_info.angle;
        o_result.phase_quadrant = i_info.quadrant;
        // cosine on the quadrant's own coil, sine on the next one round
        case (i_info.quadrant)
            2'd0: begin
                o_result.duty_a = cos_duty;
                o_result.duty_b = sin_duty;
            end
            2'd1: begin
                o_result.duty_b = cos_duty;
                o_result.duty_c = sin_duty;
            end
            2'd2: begin
                o_result.duty_c = cos_duty;
                o_result.duty_d = sin_duty;
            end
            2'd3: begin
                o_result.duty_d = cos_duty;
                o_result.duty_a = sin_duty;
            end
            default: begin
                o_result.duty_a = cos_duty;
                o_result.duty_b = sin_duty;
            end
        endcase
    end

endmodule

// File: src/stepper_microstep_pwm_generator.sv
// Sine microstepping drive for a four-coil stepper. Each input transfer is one timer tick
// carrying a speed sample and a modulation enable; each tick yields exactly one result with
// four 10-bit coil duties and the angle (microstep, quadrant) after that tick. The block
// takes one tick per clock cycle when the output side keeps up: the tick is held in an input
// register, the wait counter, angle update, table lookups and the two 8x8 modulation
// multiplies run combinationally behind it, and the result is held in an output register,
// so a result is offered once its tick moves on from the input register.
// min_wait is written through i_cfg_we/i_cfg_wdata (reset value 10) and should only change
// while no tick is in flight.
module stepper_microstep_pwm_generator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  smpg_pkg::t_in       i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output smpg_pkg::t_out      o_out_data
);

    logic                   r_in_vld;
    smpg_pkg::t_in          r_in;
    logic                   r_out_vld;
    smpg_pkg::t_out         r_out;
    logic [7:0]             r_min_wait;

    logic                   advance;
    smpg_pkg::t_step_info   info;
    smpg_pkg::t_out         result;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_wait <= smpg_pkg::MinWaitReset;
        end else if (i_cfg_we) begin
            r_min_wait <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    smpg_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_min_wait (r_min_wait),
        .i_item     (r_in),
        .o_info     (info)
    );

    smpg_duty u_duty (
        .i_info     (info),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
